@@ hw/rtl/sapw_pkg.sv @@
package sapw_pkg;

    // Sample width of the ADC and the fixed widths of the other fields.
    localparam int ADC_BITS = 12;
    localparam int DZ_W     = 10;
    localparam int TRIM_W   = 10;
    localparam int PULSE_W  = 11;

    // Pulse widths in microseconds.
    localparam int PW_LOW  = 1000;
    localparam int PW_MID  = 1500;
    localparam int PW_HIGH = 2000;
    localparam int PW_ZERO = 0;

    // Output spans of the two segment kinds.
    localparam int SPAN_HALF = 500;
    localparam int SPAN_FULL = 1000;
    localparam int SCALE_W   = 12;

    // Largest magnitude of an input difference or a segment span.
    localparam int SUM_MAX = (1 << ADC_BITS) - 1 + (1 << DZ_W) - 1;
    localparam int DEN_W   = $clog2(SUM_MAX + 1);
    localparam int DIFF_W  = DEN_W + 1;
    // Largest magnitude of a scaled difference.
    localparam int NUM_W   = $clog2(SUM_MAX * SPAN_FULL + 1);
    localparam int PROD_W  = DIFF_W + SCALE_W;
    localparam int RES_W   = NUM_W + 2;

    // Queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Register port.
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 3;
    localparam int ADDR_W     = REG_IDX_W + 2;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_MIN_VALUE   = 3'd0,
        REG_MID_VALUE   = 3'd1,
        REG_MAX_VALUE   = 3'd2,
        REG_DEAD_ZONE   = 3'd3,
        REG_TRIM_OFFSET = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [ADC_BITS-1:0] min_value;
        logic [ADC_BITS-1:0] mid_value;
        logic [ADC_BITS-1:0] max_value;
        logic [DZ_W-1:0]     dead_zone;
        logic [TRIM_W-1:0]   trim_offset;
    } t_cfg;

    // One classified sample on its way from the front to the back.
    typedef struct packed {
        logic                     is_const;
        logic                     scale_full;
        logic signed [DIFF_W-1:0] diff;
        logic signed [DIFF_W-1:0] span;
        logic [PULSE_W-1:0]       base_us;
    } t_job;

    // One stage of the divider pipeline.
    typedef struct packed {
        logic [DEN_W-1:0]   rem;
        logic [NUM_W-1:0]   dq;
        logic [DEN_W-1:0]   den;
        logic               neg;
        logic               is_const;
        logic [PULSE_W-1:0] base_us;
    } t_div;

endpackage

@@ hw/rtl/sapw_if.sv @@
// Sample channel: one raw ADC reading per beat.
interface sapw_sample_if import sapw_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [ADC_BITS-1:0] raw_sample;

    modport source (output valid, output raw_sample, input ready);
    modport sink (input valid, input raw_sample, output ready);
endinterface

// Pulse channel: one pulse width per beat.
interface sapw_pulse_if import sapw_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [PULSE_W-1:0] pulse_us;

    modport source (output valid, output pulse_us, input ready);
    modport sink (input valid, input pulse_us, output ready);
endinterface

@@ hw/rtl/sapw_cfg_regs.sv @@
module sapw_cfg_regs import sapw_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    t_cfg                 r_cfg;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign o_cfg   = r_cfg;

    // Register writes; addresses past the last register are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_value   <= '0;
            r_cfg.mid_value   <= ADC_BITS'(2048);
            r_cfg.max_value   <= '1;
            r_cfg.dead_zone   <= '0;
            r_cfg.trim_offset <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_MIN_VALUE:   r_cfg.min_value   <= pwdata[ADC_BITS-1:0];
                REG_MID_VALUE:   r_cfg.mid_value   <= pwdata[ADC_BITS-1:0];
                REG_MAX_VALUE:   r_cfg.max_value   <= pwdata[ADC_BITS-1:0];
                REG_DEAD_ZONE:   r_cfg.dead_zone   <= pwdata[DZ_W-1:0];
                REG_TRIM_OFFSET: r_cfg.trim_offset <= pwdata[TRIM_W-1:0];
                default: ;
            endcase
        end
    end

    // Read-back of the addressed register.
    always_comb begin
        case (reg_idx)
            REG_MIN_VALUE:   prdata = APB_DATA_W'(r_cfg.min_value);
            REG_MID_VALUE:   prdata = APB_DATA_W'(r_cfg.mid_value);
            REG_MAX_VALUE:   prdata = APB_DATA_W'(r_cfg.max_value);
            REG_DEAD_ZONE:   prdata = APB_DATA_W'(r_cfg.dead_zone);
            REG_TRIM_OFFSET: prdata = APB_DATA_W'(r_cfg.trim_offset);
            default:         prdata = '0;
        endcase
    end

endmodule

@@ hw/rtl/sapw_front.sv @@
module sapw_front import sapw_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_cfg   i_cfg,
    sapw_sample_if.sink i_sample,
    input  logic   i_q_full,
    output logic   o_q_push,
    output t_job   o_q_job
);

    logic r_vld;
    t_job r_job;
    t_job n_job;
    logic take;

    logic signed [DIFF_W-1:0] x_s;
    logic signed [DIFF_W-1:0] lo_s;
    logic signed [DIFF_W-1:0] mid_s;
    logic signed [DIFF_W-1:0] hi_s;
    logic signed [DIFF_W-1:0] dz_s;
    logic signed [DIFF_W-1:0] in_lo;
    logic signed [DIFF_W-1:0] in_hi;

    // The front holds one classified beat until the queue has room for it.
    assign i_sample.ready = !r_vld || !i_q_full;
    assign take           = i_sample.valid && i_sample.ready;
    assign o_q_push       = r_vld && !i_q_full;
    assign o_q_job        = r_job;

    assign x_s   = signed'(DIFF_W'(i_sample.raw_sample));
    assign lo_s  = signed'(DIFF_W'(i_cfg.min_value));
    assign mid_s = signed'(DIFF_W'(i_cfg.mid_value));
    assign hi_s  = signed'(DIFF_W'(i_cfg.max_value));
    assign dz_s  = signed'(DIFF_W'(i_cfg.dead_zone));

    // Pick the segment the sample falls in, or a fixed result.
    always_comb begin
        in_lo            = lo_s;
        in_hi            = hi_s;
        n_job.is_const   = 1'b0;
        n_job.scale_full = 1'b0;
        n_job.base_us    = PULSE_W'(PW_LOW);
        if (i_cfg.mid_value != '0) begin
            if (x_s >= mid_s - dz_s && x_s <= mid_s + dz_s) begin
                n_job.is_const = 1'b1;
                n_job.base_us  = PULSE_W'(PW_MID);
            end else if (x_s < mid_s) begin
                in_hi = mid_s - dz_s;
            end else begin
                in_lo         = mid_s + dz_s;
                n_job.base_us = PULSE_W'(PW_MID);
            end
        end else if (x_s > lo_s + dz_s) begin
            in_hi            = hi_s - dz_s;
            n_job.scale_full = 1'b1;
        end else begin
            n_job.is_const = 1'b1;
            n_job.base_us  = PULSE_W'(PW_ZERO);
        end
        n_job.diff = x_s - in_lo;
        n_job.span = in_hi - in_lo;
        // A segment of zero span gives its low output.
        if (n_job.span == '0) begin
            n_job.is_const = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (take) begin
            r_vld <= 1'b1;
        end else if (o_q_push) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_job <= n_job;
        end
    end

endmodule

@@ hw/rtl/sapw_queue.sv @@
module sapw_queue import sapw_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_job o_job
);

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

@@ hw/rtl/sapw_back.sv @@
module sapw_back import sapw_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cfg  i_cfg,
    input  logic  i_q_valid,
    input  t_job  i_q_job,
    output logic  o_q_pop,
    sapw_pulse_if.source o_pulse
);

    t_div               r_stg [NUM_W+1];
    logic               r_vld [NUM_W+1];
    t_div               n_stg [NUM_W+1];
    logic [PULSE_W-1:0] r_out;
    logic [PULSE_W-1:0] n_out;
    logic               r_out_vld;
    logic               adv;

    logic signed [SCALE_W-1:0] scale_s;
    logic signed [PROD_W-1:0]  prod;
    logic signed [PROD_W-1:0]  prod_abs;
    logic signed [DIFF_W-1:0]  span_abs;
    logic signed [RES_W-1:0]   q_s;
    logic signed [RES_W-1:0]   sum;

    // The whole pipeline moves together whenever the output register frees up.
    assign adv      = !r_out_vld || o_pulse.ready;
    assign o_q_pop  = adv && i_q_valid;
    assign o_pulse.valid    = r_out_vld;
    assign o_pulse.pulse_us = r_out;

    // Scale the difference and split the division into magnitudes and a sign.
    always_comb begin
        scale_s  = i_q_job.scale_full ? SCALE_W'(SPAN_FULL) : SCALE_W'(SPAN_HALF);
        prod     = i_q_job.diff * scale_s;
        prod_abs = prod[PROD_W-1] ? -prod : prod;
        span_abs = i_q_job.span[DIFF_W-1] ? -i_q_job.span : i_q_job.span;
        n_stg[0].rem      = '0;
        n_stg[0].dq       = prod_abs[NUM_W-1:0];
        n_stg[0].den      = span_abs[DEN_W-1:0];
        n_stg[0].neg      = prod[PROD_W-1] ^ i_q_job.span[DIFF_W-1];
        n_stg[0].is_const = i_q_job.is_const;
        n_stg[0].base_us  = i_q_job.base_us;
    end

    // One restoring division step per stage, one quotient bit each.
    for (genvar k = 0; k < NUM_W; k++) begin : g_div
        logic [DEN_W:0] trial;
        logic           ge;

        always_comb begin
            trial = {r_stg[k].rem, r_stg[k].dq[NUM_W-1]};
            ge    = (trial >= {1'b0, r_stg[k].den});
            n_stg[k+1]     = r_stg[k];
            n_stg[k+1].rem = ge ? DEN_W'(trial - {1'b0, r_stg[k].den})
                                : trial[DEN_W-1:0];
            n_stg[k+1].dq  = {r_stg[k].dq[NUM_W-2:0], ge};
        end
    end

    // Apply the sign, add the base and trim, then clamp.
    always_comb begin
        q_s = signed'(RES_W'(r_stg[NUM_W].dq));
        if (r_stg[NUM_W].neg) begin
            q_s = -q_s;
        end
        if (r_stg[NUM_W].is_const) begin
            q_s = '0;
        end
        sum = signed'(RES_W'(r_stg[NUM_W].base_us)) + q_s
            + signed'(RES_W'(i_cfg.trim_offset));
        if (sum < signed'(RES_W'(PW_LOW))) begin
            n_out = PULSE_W'(PW_LOW);
        end else if (sum > signed'(RES_W'(PW_HIGH))) begin
            n_out = PULSE_W'(PW_HIGH);
        end else begin
            n_out = sum[PULSE_W-1:0];
        end
    end

    // Valid bits of the stages and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= NUM_W; k++) begin
                r_vld[k] <= 1'b0;
            end
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_vld[0] <= i_q_valid;
            for (int k = 1; k <= NUM_W; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
            r_out_vld <= r_vld[NUM_W];
        end
    end

    // Stage payloads.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k <= NUM_W; k++) begin
                r_stg[k] <= n_stg[k];
            end
            r_out <= n_out;
        end
    end

endmodule

@@ hw/rtl/stick_adc_to_pulse_width_core.sv @@
// An accepted sample passes the front register, the queue, the divider stages and the
// output register before its pulse width is valid. Throughput: one sample per cycle
// while the output is not stalled; the divider is fully pipelined and a four-entry
// queue separates the classifying front from the divider back.
// Reset (synchronous, active low) empties the queue and the pipeline and loads
// the register defaults: min 0, mid 2048, max all ones, dead zone 0, trim 0.
module stick_adc_to_pulse_width_core import sapw_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    sapw_sample_if.sink           i_sample,
    sapw_pulse_if.source          o_pulse,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    t_cfg cfg;
    logic q_full;
    logic q_push;
    t_job q_in_job;
    logic q_valid;
    logic q_pop;
    t_job q_out_job;

    // Register file.
    sapw_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Front: accept and classify samples.
    sapw_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_sample (i_sample),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_q_job  (q_in_job)
    );

    // Queue between the two halves.
    sapw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_in_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_job   (q_out_job)
    );

    // Back: scale, divide, trim and clamp.
    sapw_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_q_valid (q_valid),
        .i_q_job   (q_out_job),
        .o_q_pop   (q_pop),
        .o_pulse   (o_pulse)
    );

endmodule
